>>> hw/rtl/cvh_pkg.sv
package cvh_pkg;

  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 32;
  localparam int ACTIVE_W = 9;
  localparam int INDEX_W  = 8;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 1;

  // product of a sample and the bin count
  localparam int PROD_W = VALUE_W + ACTIVE_W;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BINS = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [VALUE_W-1:0] sample_value;
    logic [INDEX_W-1:0] bin_index;
  } cvh_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [COUNT_W-1:0] total_count;
  } cvh_out_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

>>> hw/rtl/cvh_ram.sv
module cvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/cvh_div.sv
module cvh_div
  import cvh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PROD_W-1:0]   num,
  input  logic [VALUE_W-1:0]  den,
  output logic                done,
  output logic [ACTIVE_W-1:0] quo
);

  // restoring division, one quotient bit per cycle; caller ensures num < den * 2^ACTIVE_W
  localparam int CNT_W = $clog2(ACTIVE_W);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]  rem_r, rem_nxt;
  logic [ACTIVE_W-1:0] low_r, low_nxt;
  logic [ACTIVE_W-1:0] q_r, q_nxt;
  logic [VALUE_W:0]    trial;
  logic [VALUE_W:0]    diff;
  logic                ge;

  assign trial = {rem_r, low_r[ACTIVE_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num[PROD_W-1:ACTIVE_W];
      low_nxt  = num[ACTIVE_W-1:0];
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
      low_nxt = {low_r[ACTIVE_W-2:0], 1'b0};
      q_nxt   = {q_r[ACTIVE_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ACTIVE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

>>> hw/rtl/clamped_value_histogram.sv
// add sample: accept, then one divider step per quotient bit, a bin read and a write-back
// read bin: the bin is read into the memory's output register, then the result is registered once the output has room
// clear: one bin zeroed per cycle through the single write port
// add throughput is set by the bit-serial divider and the read-modify-write of the bin memory
// after reset a sweep zeroes the bin memory; no item is taken until it ends,
// configuration writes are taken at any time
module clamped_value_histogram
  import cvh_pkg::*;
#(
  parameter int BINS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cvh_in_t              in_data,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output cvh_out_t             out_data,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(BINS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLR  = 6'b000010,
    S_DIV  = 6'b000100,
    S_WB   = 6'b001000,
    S_RDO  = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [VALUE_W-1:0]  limit_r, limit_nxt;
  logic [ACTIVE_W-1:0] bins_r, bins_nxt;

  // running state and item context
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]    bin_r, bin_nxt;
  logic                over_r, over_nxt;
  logic                oob_r, oob_nxt;
  logic                out_valid_r, out_valid_nxt;
  cvh_out_t            out_data_r, out_data_nxt;

  // effective bin count, clamped to 1..BINS
  logic [ACTIVE_W-1:0] b_eff;
  logic [IDX_W-1:0]    b_top;
  logic [PROD_W-1:0]   prod;
  logic                in_acc;

  // divider
  logic                div_start;
  logic                div_done;
  logic [ACTIVE_W-1:0] div_quo;

  // bin memory ports
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [COUNT_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [COUNT_W-1:0]  ram_rdata;

  always_comb begin
    if (bins_r == '0) begin
      b_eff = ACTIVE_W'(1);
    end else if (32'(bins_r) > 32'(BINS)) begin
      b_eff = ACTIVE_W'(BINS);
    end else begin
      b_eff = bins_r;
    end
  end

  assign b_top  = IDX_W'(b_eff - 1'b1);
  assign prod   = PROD_W'(in_data.sample_value) * PROD_W'(b_eff);
  assign in_acc = in_valid && !in_stall;

  // a value at or past the limit (or a zero limit) lands in the top bin;
  // below it the quotient is always under the bin count
  cvh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod),
    .den   (limit_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  cvh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // register writes, taken in every state
  always_comb begin
    limit_nxt = limit_r;
    bins_nxt  = bins_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RANGE_LIMIT: limit_nxt = cfg_data;
        CFG_ACTIVE_BINS: bins_nxt  = cfg_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    clr_cnt_nxt   = clr_cnt_r;
    bin_nxt       = bin_r;
    over_nxt      = over_r;
    oob_nxt       = oob_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = bin_r;
    ram_wdata     = sat_inc(ram_rdata);
    ram_re        = 1'b0;
    ram_raddr     = IDX_W'(in_data.bin_index);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            OP_ADD: begin
              div_start = 1'b1;
              over_nxt  = (in_data.sample_value >= limit_r);
              total_nxt = sat_inc(total_r);
              state_nxt = S_DIV;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              oob_nxt   = (32'(in_data.bin_index) >= 32'(BINS));
              state_nxt = S_RDO;
            end
            OP_CLEAR: begin
              total_nxt   = '0;
              clr_cnt_nxt = '0;
              state_nxt   = S_CLR;
            end
            default: ;  // unused opcode is dropped
          endcase
        end
      end
      S_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          bin_nxt   = over_r ? b_top : IDX_W'(div_quo);
          ram_re    = 1'b1;
          ram_raddr = bin_nxt;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        // read data of the chosen bin is here, write back the bumped count
        ram_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RDO: begin
        // wait for room in the output register
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.bin_count   = oob_r ? '0 : ram_rdata;
          out_data_nxt.total_count = total_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      total_r     <= '0;
      limit_r     <= {VALUE_W{1'b1}};
      bins_r      <= ACTIVE_W'(256);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      total_r     <= total_nxt;
      limit_r     <= limit_nxt;
      bins_r      <= bins_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r      <= bin_nxt;
    over_r     <= over_nxt;
    oob_r      <= oob_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // a new result only comes out of the read wait state
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RDO))
    else $error("result appeared without a bin read");

  // divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside division wait");

  // write-back always follows a finished division
  a_wb_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> $past(state_r == S_DIV) && $past(div_done))
    else $error("bin write-back without a bin choice");

  // a clear item zeroes the total at once
  a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.opcode == OP_CLEAR)) |=> (total_r == '0) && (state_r == S_CLR))
    else $error("clear did not reset the total");

endmodule

>>> tb/sv/clamped_value_histogram_test.sv
module clamped_value_histogram_test;
  import cvh_pkg::*;

  localparam int BINS        = 256;
  // only opcode with no name in the package, the block ignores it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // a clear walks all bins, so that bounds the quiet time after the last result
  localparam int SETTLE      = BINS + 64;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;
  localparam int SEGMENTS    = 9;
  localparam int SEG_ITEMS   = 155;

  // shadow copy of the histogram plus the queue of read results still owed
  class histogram_shadow;
    logic [COUNT_W-1:0]  counts [BINS];
    logic [COUNT_W-1:0]  total;
    logic [VALUE_W-1:0]  range_limit;
    logic [ACTIVE_W-1:0] active_bins;
    cvh_out_t            readouts_due [$];
    int                  errors;

    function new();
      foreach (counts[i]) counts[i] = '0;
      total       = '0;
      range_limit = '1;
      active_bins = ACTIVE_W'(BINS);
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
      if (idx == CFG_RANGE_LIMIT) range_limit = data;
      else if (idx == CFG_ACTIVE_BINS) active_bins = data[ACTIVE_W-1:0];
    endfunction

    function int eff_bins();
      int b;
      b = int'(active_bins);
      if (b < 1) b = 1;
      if (b > BINS) b = BINS;
      return b;
    endfunction

    // exact quotient, clamped to the top active bin
    function int bin_of(logic [VALUE_W-1:0] value);
      logic [63:0] q;
      int          b;
      b = eff_bins();
      if (range_limit == '0) return b - 1;
      q = (64'(value) * 64'(b)) / 64'(range_limit);
      if (q > 64'(b - 1)) q = 64'(b - 1);
      return int'(q);
    endfunction

    function void take_item(cvh_in_t it);
      cvh_out_t r;
      int       b;
      case (it.opcode)
        OP_ADD: begin
          b = bin_of(it.sample_value);
          if (counts[b] != '1) counts[b] = counts[b] + 1'b1;
          if (total != '1) total = total + 1'b1;
        end
        OP_READ: begin
          r.bin_count   = (int'(it.bin_index) < BINS) ? counts[it.bin_index] : '0;
          r.total_count = total;
          readouts_due.push_back(r);
        end
        OP_CLEAR: begin
          foreach (counts[i]) counts[i] = '0;
          total = '0;
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      if (errors < 10)
        $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
      errors++;
    endfunction

    function void match_readout(cvh_out_t got);
      cvh_out_t want;
      if (readouts_due.size() == 0) begin
        if (errors < 10)
          $display("%0t: result with none pending, count %0d total %0d",
                   $realtime, got.bin_count, got.total_count);
        errors++;
        return;
      end
      want = readouts_due.pop_front();
      if (got.bin_count !== want.bin_count) flag("bin_count", want.bin_count, got.bin_count);
      if (got.total_count !== want.total_count)
        flag("total_count", want.total_count, got.total_count);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cvh_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  cvh_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VALUE_W-1:0]   cfg_data;

  histogram_shadow shadow = new();

  // idle rates in percent, written only by the main sequence
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  // each bump asks the receiver for one long hold-off
  int hold_req       = 0;
  int quiet_cycles   = 0;

  clamped_value_histogram #(.BINS(BINS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // everything is sampled here at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
          (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (cfg_valid && cfg_ready) begin
        shadow.write_reg(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        shadow.take_item(in_data);
      end
      if (out_valid && !out_stall) begin
        shadow.match_readout(out_data);
      end
      // no handshake for far longer than a clear plus the longest hold-off
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("clamped_value_histogram test failed");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold-off when one is asked for
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic cvh_in_t mk(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val,
                                 logic [INDEX_W-1:0] idx);
    cvh_in_t it;
    it.opcode       = op;
    it.sample_value = val;
    it.bin_index    = idx;
    return it;
  endfunction

  // offer one item, maybe after a short gap, and hold it until taken
  task automatic send_item(cvh_in_t it);
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for every owed result, then let a pending add or clear run out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (shadow.readouts_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // mostly adds, with reads, some clears and a little of the unused opcode
  function automatic cvh_in_t random_item();
    cvh_in_t            it;
    int                 roll;
    int                 b;
    logic [VALUE_W-1:0] lim;
    logic [63:0]        edge_val;
    it   = mk(OP_ADD, $urandom, INDEX_W'($urandom));
    roll = $urandom_range(99);
    b    = shadow.eff_bins();
    lim  = shadow.range_limit;
    if (roll < 4) begin
      it.opcode = OP_UNUSED;
    end else if (roll < 7) begin
      it.opcode = OP_CLEAR;
    end else if (roll < 30) begin
      it.opcode = OP_READ;
      // at least half the reads land inside the active bins
      if ($urandom_range(1)) it.bin_index = INDEX_W'($urandom_range(b - 1));
    end else begin
      case ($urandom_range(2))
        0: it.sample_value = $urandom;
        1: it.sample_value = (lim == '0) ? $urandom_range(255) : $urandom_range(lim);
        default: begin
          // right at a bin boundary, or one off either side
          edge_val = (64'(lim) * 64'($urandom_range(b))) / 64'(b);
          it.sample_value = edge_val[31:0] + $urandom_range(2) - 1;
        end
      endcase
    end
    return it;
  endfunction

  initial begin : main_seq
    logic [VALUE_W-1:0] seg_limit [SEGMENTS];
    logic [VALUE_W-1:0] seg_bins  [SEGMENTS];
    cvh_in_t            it;
    int                 n;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RANGE_LIMIT;
    cfg_data  = '0;

    // register settings per segment, extremes and the out-of-range bin counts
    seg_limit = '{32'hFFFF_FFFF, 32'd1000, 32'd0, 32'd1, $urandom,
                  32'h7FFF_FFFF, 32'd255, 32'hFFFF_FFFF, $urandom};
    seg_bins  = '{32'd256, 32'd10, 32'd256, 32'd0, 32'hABCD_E12C,
                  32'd7, 32'd511, 32'd1, 32'($urandom_range(1, BINS))};

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, full-scale edges, every opcode
    send_item(mk(OP_ADD, 32'h0000_0000, 8'h00));
    send_item(mk(OP_ADD, 32'hFFFF_FFFF, 8'h00));   // quotient equals bin count, clamped
    send_item(mk(OP_ADD, 32'h8000_0000, 8'h00));
    send_item(mk(OP_ADD, 32'h00FF_FFFF, 8'h00));   // last value of bin 0
    send_item(mk(OP_ADD, 32'h0100_0000, 8'h00));   // first value past bin 0
    send_item(mk(OP_ADD, 32'h7FFF_FFFF, 8'h00));
    send_item(mk(OP_READ, 32'h0, 8'd0));
    send_item(mk(OP_READ, 32'h0, 8'd1));
    send_item(mk(OP_READ, 32'h0, 8'd127));
    send_item(mk(OP_READ, 32'h0, 8'd128));
    send_item(mk(OP_READ, 32'h0, 8'd255));
    send_item(mk(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF)); // must leave the state alone
    send_item(mk(OP_READ, 32'hFFFF_FFFF, 8'd255));  // unused field all ones
    send_item(mk(OP_CLEAR, 32'hFFFF_FFFF, 8'hFF));
    send_item(mk(OP_READ, 32'h0, 8'd0));
    send_item(mk(OP_READ, 32'h0, 8'd255));
    send_item(mk(OP_ADD, 32'hFFFF_FFFE, 8'hFF));
    send_item(mk(OP_READ, 32'hFFFF_FFFF, 8'd255));
    send_item(mk(OP_READ, 32'h5555_AAAA, 8'd200));

    // random segments: sender idles lightly first, then the receiver, then neither
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0:       begin send_gap_pct = 6;  recv_stall_pct = 77; end
        1:       begin send_gap_pct = 77; recv_stall_pct = 6;  end
        default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      drain();
      cfg_write(CFG_RANGE_LIMIT, seg_limit[seg]);
      cfg_write(CFG_ACTIVE_BINS, seg_bins[seg]);

      // receiver holds off while reads keep coming, so the input backs up
      if (seg == 6) begin
        hold_req++;
        repeat (40) send_item(mk(OP_READ, $urandom, INDEX_W'($urandom)));
      end

      n = 0;
      while (n < SEG_ITEMS) begin
        it = random_item();
        send_item(it);
        if (it.opcode != OP_UNUSED) n++;
      end
    end

    drain();
    if (shadow.errors == 0 && shadow.readouts_due.size() == 0) begin
      $display("clamped_value_histogram test passed");
    end else begin
      $display("clamped_value_histogram test failed");
    end
    $finish;
  end

endmodule

>>> clamped_value_histogram.f
hw/rtl/cvh_pkg.sv
hw/rtl/cvh_ram.sv
hw/rtl/cvh_div.sv
hw/rtl/clamped_value_histogram.sv
tb/sv/clamped_value_histogram_test.sv
